[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/dtta_pkg.sv]
package dtta_pkg;

	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_Q_LEN   = 4'd1,
		PH_Q_LABEL = 4'd2,
		PH_Q_PTR   = 4'd3,
		PH_Q_FIXED = 4'd4,
		PH_R_LEN   = 4'd5,
		PH_R_LABEL = 4'd6,
		PH_R_PTR   = 4'd7,
		PH_R_TYPE  = 4'd8,
		PH_R_CLASS = 4'd9,
		PH_R_TTL   = 4'd10,
		PH_R_RDLEN = 4'd11,
		PH_R_RDATA = 4'd12,
		PH_DONE    = 4'd13
	} phase_t;

	localparam logic [7:0]  PTR_MARK = 8'hc0;
	localparam logic [3:0]  HDR_LEN  = 4'd12;
	localparam logic [15:0] TYPE_OPT = 16'd41;

	localparam int unsigned Q_DEPTH = 8;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	// One queue entry: up to four output bytes, first byte in the top bits.
	typedef struct packed {
		logic [31:0] data;
		logic [1:0]  cnt;   // number of bytes minus one
		logic        last;
	} entry_t;

	typedef struct packed {
		phase_t phase;
		logic   ttl_hold;   // TTL byte would be held rather than sent on
	} fe_stat_t;

endpackage

[rtl/core/dtta_front.sv]
module dtta_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [31:0]         age_seconds,
	output logic                q_push,
	output dtta_pkg::entry_t    q_entry,
	output dtta_pkg::fe_stat_t  stat
);
	import dtta_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [15:0] qleft_q, qleft_d;
	logic [17:0] rleft_q, rleft_d;
	logic [15:0] skip_q, skip_d;
	logic [7:0]  hi_q, hi_d;
	logic [23:0] held_q, held_d;
	logic [31:0] age_q, age_d;

	always_comb begin
		logic        sect;
		logic        pass;
		logic [15:0] v;
		logic [31:0] ttl;
		phase_d = phase_q;
		idx_d   = idx_q;
		qleft_d = qleft_q;
		rleft_d = rleft_q;
		skip_d  = skip_q;
		hi_d    = hi_q;
		held_d  = held_q;
		age_d   = age_q;
		sect    = 1'b0;
		pass    = 1'b1;
		v       = {hi_q, data_byte};
		ttl     = {held_q, data_byte} - age_q;
		q_push  = 1'b0;
		q_entry = '{data: {data_byte, 24'd0}, cnt: 2'd0, last: last_byte};

		case (phase_q)
			PH_HDR: begin
				if (idx_q == 4'd0) begin
					age_d = age_seconds;
				end
				if (idx_q >= 4'd4) begin
					if (!idx_q[0]) begin
						hi_d = data_byte;
					end else if (idx_q == 4'd5) begin
						qleft_d = v;
					end else begin
						rleft_d = rleft_q + {2'd0, v};
					end
				end
				idx_d = idx_q + 4'd1;
				if (idx_d >= HDR_LEN) begin
					sect = 1'b1;
				end
			end
			PH_Q_LEN, PH_R_LEN: begin
				if (data_byte == 8'd0) begin
					phase_d = (phase_q == PH_Q_LEN) ? PH_Q_FIXED : PH_R_TYPE;
					idx_d   = 4'd0;
				end else if (data_byte >= PTR_MARK) begin
					phase_d = (phase_q == PH_Q_LEN) ? PH_Q_PTR : PH_R_PTR;
				end else begin
					skip_d  = {8'd0, data_byte};
					phase_d = (phase_q == PH_Q_LEN) ? PH_Q_LABEL : PH_R_LABEL;
				end
			end
			PH_Q_LABEL, PH_R_LABEL: begin
				skip_d = skip_q - 16'd1;
				if (skip_d == 16'd0) begin
					phase_d = (phase_q == PH_Q_LABEL) ? PH_Q_LEN : PH_R_LEN;
				end
			end
			PH_Q_PTR: begin
				phase_d = PH_Q_FIXED;
				idx_d   = 4'd0;
			end
			PH_R_PTR: begin
				phase_d = PH_R_TYPE;
				idx_d   = 4'd0;
			end
			PH_Q_FIXED: begin
				idx_d = idx_q + 4'd1;
				if (idx_d >= 4'd4) begin
					qleft_d = qleft_q - 16'd1;
					sect    = 1'b1;
				end
			end
			PH_R_TYPE: begin
				if (idx_q == 4'd0) begin
					hi_d  = data_byte;
					idx_d = 4'd1;
				end else if (v == TYPE_OPT) begin
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_R_CLASS;
					idx_d   = 4'd0;
				end
			end
			PH_R_CLASS: begin
				idx_d = idx_q + 4'd1;
				if (idx_d >= 4'd2) begin
					phase_d = PH_R_TTL;
					idx_d   = 4'd0;
					held_d  = 24'd0;
				end
			end
			PH_R_TTL: begin
				if (idx_q < 4'd3) begin
					if (last_byte) begin
						// Message ends inside the TTL: the held bytes go out unaged.
						pass = 1'b0;
						q_push = 1'b1;
						q_entry.cnt = idx_q[1:0];
						case (idx_q[1:0])
							2'd1:    q_entry.data = {held_q[7:0], data_byte, 16'd0};
							2'd2:    q_entry.data = {held_q[15:0], data_byte, 8'd0};
							default: q_entry.data = {data_byte, 24'd0};
						endcase
					end else begin
						held_d = {held_q[15:0], data_byte};
						idx_d  = idx_q + 4'd1;
						pass   = 1'b0;
					end
				end else begin
					pass        = 1'b0;
					q_push      = 1'b1;
					q_entry.data = ttl;
					q_entry.cnt = 2'd3;
					phase_d     = PH_R_RDLEN;
					idx_d       = 4'd0;
				end
			end
			PH_R_RDLEN: begin
				if (idx_q == 4'd0) begin
					hi_d  = data_byte;
					idx_d = 4'd1;
				end else begin
					skip_d = v;
					if (v == 16'd0) begin
						rleft_d = rleft_q - 18'd1;
						sect    = 1'b1;
					end else begin
						phase_d = PH_R_RDATA;
					end
				end
			end
			PH_R_RDATA: begin
				skip_d = skip_q - 16'd1;
				if (skip_d == 16'd0) begin
					rleft_d = rleft_q - 18'd1;
					sect    = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Move on to the next question or record, or finish the message.
		if (sect) begin
			idx_d = 4'd0;
			if (qleft_d != 16'd0) begin
				phase_d = PH_Q_LEN;
			end else if (rleft_d != 18'd0) begin
				phase_d = PH_R_LEN;
			end else begin
				phase_d = PH_DONE;
			end
		end

		if (pass) begin
			q_push = 1'b1;
		end
		q_push = q_push & accept;

		if (last_byte) begin
			phase_d = PH_HDR;
			idx_d   = 4'd0;
			qleft_d = 16'd0;
			rleft_d = 18'd0;
			skip_d  = 16'd0;
			hi_d    = 8'd0;
			held_d  = 24'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			idx_q   <= 4'd0;
			qleft_q <= 16'd0;
			rleft_q <= 18'd0;
			skip_q  <= 16'd0;
			hi_q    <= 8'd0;
			held_q  <= 24'd0;
			age_q   <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			qleft_q <= qleft_d;
			rleft_q <= rleft_d;
			skip_q  <= skip_d;
			hi_q    <= hi_d;
			held_q  <= held_d;
			age_q   <= age_d;
		end
	end

	assign stat.phase    = phase_q;
	assign stat.ttl_hold = (phase_q == PH_R_TTL) && (idx_q < 4'd3);

endmodule

[rtl/core/dtta_queue.sv]
module dtta_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dtta_pkg::entry_t  wr_entry,
	input  logic              deq,
	output dtta_pkg::entry_t  head,
	output logic              full,
	output logic              empty
);
	import dtta_pkg::*;

	entry_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push, do_deq;

	assign full    = (cnt_q == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_deq  = deq && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (do_deq) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (do_push && !do_deq) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (do_deq && !do_push) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

[rtl/core/dtta_back.sv]
module dtta_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dtta_pkg::entry_t  head,
	input  logic              q_empty,
	input  logic              pop,
	output logic              deq,
	output logic [7:0]        out_byte,
	output logic              out_last
);
	import dtta_pkg::*;

	logic [1:0] sel_q;
	logic       beat;
	logic       at_end;

	assign beat   = pop && !q_empty;
	assign at_end = (sel_q == head.cnt);
	assign deq    = beat && at_end;

	always_comb begin
		case (sel_q)
			2'd0:    out_byte = head.data[31:24];
			2'd1:    out_byte = head.data[23:16];
			2'd2:    out_byte = head.data[15:8];
			default: out_byte = head.data[7:0];
		endcase
	end

	// Only the final byte of an entry can close the message.
	assign out_last = head.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 2'd0;
		end else if (beat) begin
			sel_q <= at_end ? 2'd0 : sel_q + 2'd1;
		end
	end

endmodule

[rtl/core/dns_ttl_ager.sv]
// The first three TTL bytes of a record are held back and leave with the fourth, aged,
// over four beats.
// Throughput: one byte per cycle on each side; the back end sends one byte a cycle while pop
// is high and the queue is not empty, from an eight-entry queue that absorbs the three-byte
// lag of each TTL, and the parser takes a byte every cycle while the queue has room.
// Reset (arst_n low, asynchronous): parser returns to the header phase, the latched age
// clears to zero and the queue and byte serialiser are emptied.
`include "assert_macros.svh"

module dns_ttl_ager (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [31:0] age_seconds,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_last
);
	import dtta_pkg::*;

	logic     accept;
	logic     q_push;
	entry_t   q_entry;
	entry_t   head;
	logic     deq;
	fe_stat_t stat;

	assign accept = push && !full;

	dtta_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.age_seconds (age_seconds),
		.q_push      (q_push),
		.q_entry     (q_entry),
		.stat        (stat)
	);

	dtta_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_entry),
		.deq      (deq),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	dtta_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (empty),
		.pop      (pop),
		.deq      (deq),
		.out_byte (out_byte),
		.out_last (out_last)
	);

	`ASSERT_IMPLIES(a_full_not_empty, full, !empty)
	`ASSERT_NEXT(a_last_restarts_hdr, accept && last_byte, stat.phase == PH_HDR)
	`ASSERT_IMPLIES(a_held_ttl_no_push, accept && stat.ttl_hold && !last_byte, !q_push)

endmodule

[tb/sv/testbench.sv]
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dtta_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	// Tracks the parser state of the block and holds the bytes that should come out.
	class ttl_scoreboard;
		phase_t      phase;
		logic [3:0]  idx;
		logic [15:0] q_left;
		logic [17:0] r_left;
		logic [15:0] skip;
		logic [7:0]  hi;
		logic [23:0] held;
		logic [31:0] age;
		beat_t       due[$];
		int          errors;

		function new();
			restart();
			age = '0;
			errors = 0;
		endfunction

		function void restart();
			phase = PH_HDR;
			idx = '0;
			q_left = '0;
			r_left = '0;
			skip = '0;
			hi = '0;
			held = '0;
		endfunction

		function void next_section();
			idx = '0;
			if (q_left != 0)
				phase = PH_Q_LEN;
			else if (r_left != 0)
				phase = PH_R_LEN;
			else
				phase = PH_DONE;
		endfunction

		function void end_record();
			r_left = r_left - 1'b1;
			next_section();
		endfunction

		function void name_len(logic [7:0] b, phase_t label_ph, phase_t ptr_ph,
				phase_t after_ph);
			if (b == 0) begin
				phase = after_ph;
				idx = '0;
			end else if (b >= PTR_MARK) begin
				phase = ptr_ph;
			end else begin
				skip = {8'h00, b};
				phase = label_ph;
			end
		endfunction

		function void add_beat(logic [7:0] b);
			beat_t e;
			e.data = b;
			e.last = 1'b0;
			due.insert(due.size(), e);
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_byte(logic [7:0] b, logic l, logic [31:0] a);
			logic        pass_on;
			logic [15:0] v;
			logic [31:0] ttl;
			logic [23:0] sh;
			pass_on = 1'b1;
			case (phase)
				PH_HDR: begin
					if (idx == 0)
						age = a;
					if (idx >= 4) begin
						if (!idx[0]) begin
							hi = b;
						end else begin
							v = {hi, b};
							if (idx == 5)
								q_left = v;
							else
								r_left = r_left + v;
						end
					end
					idx++;
					if (idx >= HDR_LEN)
						next_section();
				end
				PH_Q_LEN: name_len(b, PH_Q_LABEL, PH_Q_PTR, PH_Q_FIXED);
				PH_R_LEN: name_len(b, PH_R_LABEL, PH_R_PTR, PH_R_TYPE);
				PH_Q_LABEL, PH_R_LABEL: begin
					skip--;
					if (skip == 0)
						phase = (phase == PH_Q_LABEL) ? PH_Q_LEN : PH_R_LEN;
				end
				PH_Q_PTR: begin
					phase = PH_Q_FIXED;
					idx = '0;
				end
				PH_R_PTR: begin
					phase = PH_R_TYPE;
					idx = '0;
				end
				PH_Q_FIXED: begin
					idx++;
					if (idx >= 4) begin
						q_left--;
						next_section();
					end
				end
				PH_R_TYPE: begin
					if (idx == 0) begin
						hi = b;
						idx = 4'd1;
					end else if ({hi, b} == TYPE_OPT) begin
						phase = PH_DONE;
					end else begin
						phase = PH_R_CLASS;
						idx = '0;
					end
				end
				PH_R_CLASS: begin
					idx++;
					if (idx >= 2) begin
						phase = PH_R_TTL;
						idx = '0;
						held = '0;
					end
				end
				PH_R_TTL: begin
					if (idx < 3) begin
						if (l) begin
							// The message ended inside the TTL: held bytes leave untouched.
							for (int i = 0; i < idx; i++) begin
								sh = held >> (8 * (idx - 1 - i));
								add_beat(sh[7:0]);
							end
						end else begin
							held = {held[15:0], b};
							idx++;
							pass_on = 1'b0;
						end
					end else begin
						ttl = {held, b} - age;
						add_beat(ttl[31:24]);
						add_beat(ttl[23:16]);
						add_beat(ttl[15:8]);
						add_beat(ttl[7:0]);
						pass_on = 1'b0;
						phase = PH_R_RDLEN;
						idx = '0;
					end
				end
				PH_R_RDLEN: begin
					if (idx == 0) begin
						hi = b;
						idx = 4'd1;
					end else begin
						skip = {hi, b};
						if (skip == 0)
							end_record();
						else
							phase = PH_R_RDATA;
					end
				end
				PH_R_RDATA: begin
					skip--;
					if (skip == 0)
						end_record();
				end
				default: ;
			endcase
			if (pass_on)
				add_beat(b);
			if (l) begin
				due[due.size() - 1].last = 1'b1;
				restart();
			end
		endfunction

		function void check_byte(logic [7:0] b, logic l);
			beat_t e;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: byte %02h last %0d", b, l);
			end else begin
				e = due.pop_front();
				if (e.data !== b || e.last !== l) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %02h last %0d, got %02h last %0d",
							e.data, e.last, b, l);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [31:0] age_seconds;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        out_last;

	ttl_scoreboard sb;
	logic [7:0]    msg[$];
	int            ttl_at;
	bit            src_idle;
	bit            sink_idle;

	dns_ttl_ager u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.age_seconds(age_seconds),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && sb != null) begin
			if (push && !full)
				sb.note_byte(data_byte, last_byte, age_seconds);
			if (pop && !empty)
				sb.check_byte(out_byte, out_last);
		end
	end

	// Receiver: after each beat it may hold pop low, when sink_idle is set.
	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = sink_idle ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Push stays high between back-to-back beats so it is never lowered and raised in one step.
	task automatic send_byte(input logic [7:0] b, input logic l, input logic [31:0] a);
		int gap;
		gap = src_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		age_seconds <= a;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_message(input logic [31:0] age, output int sent);
		sent = msg.size();
		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1, (i == 0) ? age : $urandom);
	endtask

	// The final beat is noted at the edge just passed, so look from the next edge on.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic void put8(logic [7:0] b);
		msg.insert(msg.size(), b);
	endfunction

	function automatic void put16(int unsigned v);
		put8(8'(v >> 8));
		put8(8'(v));
	endfunction

	function automatic void put_name();
		int labels;
		int len;
		labels = $urandom_range(0, 2);
		repeat (labels) begin
			len = $urandom_range(1, 3);
			put8(8'(len));
			repeat (len) put8(8'($urandom));
		end
		if ($urandom_range(0, 2) == 0) begin
			put8(8'($urandom_range(PTR_MARK, 255)));
			put8(8'($urandom));
		end else begin
			put8(8'h00);
		end
	endfunction

	function automatic void put_record();
		logic [15:0] rtype;
		logic [31:0] ttl;
		int          rdlen;
		put_name();
		case ($urandom_range(0, 5))
			0: rtype = TYPE_OPT;
			1: rtype = 16'($urandom);
			default: rtype = 16'($urandom_range(1, 64));
		endcase
		put16(rtype);
		put16($urandom);
		if (rtype != TYPE_OPT && ttl_at < 0)
			ttl_at = msg.size();
		case ($urandom_range(0, 3))
			0: ttl = 32'h0000_0000;
			1: ttl = 32'hffff_ffff;
			default: ttl = $urandom;
		endcase
		put16(ttl >> 16);
		put16(ttl);
		rdlen = $urandom_range(0, 4);
		put16(rdlen);
		repeat (rdlen) put8(8'($urandom));
	endfunction

	function automatic void make_message();
		int          kind;
		int          qd;
		int          rr;
		int          k;
		int          n;
		int unsigned cnt[3];
		msg.delete();
		ttl_at = -1;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			n = $urandom_range(1, 16);
			repeat (n) put8(8'($urandom));
		end else begin
			qd = $urandom_range(0, 2);
			rr = $urandom_range((kind == 2) ? 1 : 0, 3);
			cnt = '{0, 0, 0};
			repeat (rr) begin
				k = $urandom_range(0, 2);
				cnt[k]++;
			end
			repeat (4) put8(8'($urandom));
			if (kind == 1) begin
				repeat (4) put16($urandom);
			end else begin
				put16(qd);
				put16(cnt[0]);
				put16(cnt[1]);
				put16(cnt[2]);
			end
			repeat (qd) begin
				put_name();
				repeat (4) put8(8'($urandom));
			end
			repeat (rr) put_record();
			n = $urandom_range(0, 2);
			repeat (n) put8(8'($urandom));
			// Cut the message short, inside or at the end of a TTL or anywhere at all, or keep it whole.
			if (kind == 2 && ttl_at >= 0)
				n = ttl_at + $urandom_range(1, 4);
			else if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, msg.size());
			else
				n = msg.size();
			while (msg.size() > n) void'(msg.pop_back());
		end
	endfunction

	initial begin
		int          sent;
		int          total;
		int          waited;
		logic [31:0] age;
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		age_seconds = '0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A one-byte message, then a single record whose zero TTL wraps under an age of one.
		msg = '{8'hff};
		send_message(32'hffff_ffff, sent);
		msg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_message(32'h0000_0001, sent);
		drain();

		total = 0;
		while (total < 280) begin
			make_message();
			src_idle = $urandom_range(0, 3) != 0;
			sink_idle = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 4))
				0: age = 32'h0000_0000;
				1: age = 32'hffff_ffff;
				2: age = $urandom_range(0, 100000);
				default: age = $urandom;
			endcase
			send_message(age, sent);
			total += sent;
			if ($urandom_range(0, 7) == 0)
				drain();
		end
		push <= 1'b0;

		waited = 0;
		while (sb.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0d beats never arrived", sb.pending());
		end
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

`default_nettype wire

[dns_ttl_ager.f]
+incdir+rtl/core
rtl/core/dtta_pkg.sv
rtl/core/dtta_front.sv
rtl/core/dtta_queue.sv
rtl/core/dtta_back.sv
rtl/core/dns_ttl_ager.sv
tb/sv/testbench.sv
